FILE: rtl/joystick_servo_calibrator_assert.svh
// Assertion macros shared by the joystick servo calibrator RTL
`ifndef JOYSTICK_SERVO_CALIBRATOR_ASSERT_SVH
`define JOYSTICK_SERVO_CALIBRATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define JSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low
`define JSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSC_ASSERT_SAME(label, ante, cons, msg)
`define JSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/jsc_pkg.sv
// Types and constants shared by the joystick servo calibrator modules
`timescale 1ns / 1ps

package jsc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int PULSE_BITS  = 15;
    localparam int CMP_BITS    = 12;
    localparam int PHASE_BITS  = 3;
    localparam int DEB_BITS    = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;

    // Magnitude of base * den + num * span, and its signed form
    localparam int DIV_W   = PULSE_BITS + SAMPLE_BITS + 1;
    localparam int TOTAL_W = DIV_W + 1;

    localparam logic [PULSE_BITS-1:0] PERIOD_US = 15'd20000;

    // Divide by five: multiply by reciprocal, exact for 16-bit operands
    localparam int RECIP_W = 32;
    localparam logic [RECIP_W-1:0] RECIP5 = 32'd52429;
    localparam int RECIP5_SHIFT = 18;

    localparam logic [DEB_BITS-1:0]    DEBOUNCE_RST = 8'd10;
    localparam logic [PULSE_BITS-1:0]  BASE_RST     = 15'd900;
    localparam logic [PULSE_BITS-1:0]  SPAN_RST     = 15'd1200;
    localparam logic [SAMPLE_BITS-1:0] BOUND_RST    = 12'd2000;
    localparam logic [DEB_BITS-1:0]    STEADY_MAX   = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_BASE     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_SPAN     = 2'd2;

    // Calibration phases
    localparam logic [PHASE_BITS-1:0] PH_X_MAX  = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_X_MIN  = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_Y_MAX  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_Y_MIN  = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_MAP_XY = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_MAP_Y  = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_DONE   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_FINISH,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
        logic                   button_level;
    } jsc_in_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase_now;
        logic [SAMPLE_BITS-1:0] bound_x_high;
        logic [SAMPLE_BITS-1:0] bound_x_low;
        logic [SAMPLE_BITS-1:0] bound_y_high;
        logic [SAMPLE_BITS-1:0] bound_y_low;
        logic [PULSE_BITS-1:0]  x_pulse_us;
        logic [PULSE_BITS-1:0]  y_pulse_us;
        logic [CMP_BITS-1:0]    x_compare;
        logic [CMP_BITS-1:0]    y_compare;
        logic                   x_pulse_valid;
        logic                   y_pulse_valid;
    } jsc_out_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic axis_y;
        logic div_start;
        logic store;
        logic finish;
        logic out_load;
    } jsc_cmd_t;

    typedef struct packed {
        logic map_xy;
        logic map_y;
        logic bypass;
        logic div_busy;
        logic div_done;
        logic out_free;
    } jsc_stat_t;

endpackage

FILE: rtl/joystick_servo_calibrator.sv
// Top level of the joystick servo calibrator
//
//   channel  | signals                          | direction | word
//   ---------+----------------------------------+-----------+---------------------------
//   tick     | tick_valid, tick_ready, tick     | in        | x, y sample, button level
//   report   | report_valid, report_ready, ...  | out       | phase, bounds, pulses, cmp
//   config   | cfg_we, cfg_index, cfg_data      | in        | one register per write
//
// One tick word at a time. Capture phases and the done phase go from accept
// through the decide, finish and emit states to the report. Mapping runs one
// shared divider (2 quotient bits per cycle) per axis, x first in the two-axis phase.
// Reset (rst_n low, asynchronous) restores the configuration defaults, phase 0,
// bounds of 2000 and invalid pulses. A stalled report holds in its output
// register; the next tick is taken while it waits and holds before the report
// load until the register frees.
`timescale 1ns / 1ps

`include "joystick_servo_calibrator_assert.svh"

module joystick_servo_calibrator import jsc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    output logic                     tick_ready,
    input  jsc_in_t                  tick,
    output logic                     report_valid,
    input  logic                     report_ready,
    output jsc_out_t                 report,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    jsc_cmd_t  cmd;
    jsc_stat_t stat;

    // Sequence each tick: latch, map the live axes, update debounce, emit
    jsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Hold all calibration state and the report register
    jsc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report)
    );

    // Drop ready right after a tick is taken
    `JSC_ASSERT_NEXT(a_busy_after_accept, tick_valid && tick_ready, !tick_ready, "ready held after accept")
    // Never overwrite a report that is still waiting
    `JSC_ASSERT_SAME(a_no_overwrite, cmd.out_load, stat.out_free, "report overwritten while stalled")
    // Start the divider only when it is idle
    `JSC_ASSERT_SAME(a_div_idle, cmd.div_start && !stat.bypass, !stat.div_busy, "divider restarted while busy")
    // An x axis without a pulse reports zeros
    `JSC_ASSERT_SAME(a_x_invalid_zero, report_valid && !report.x_pulse_valid, report.x_pulse_us == '0 && report.x_compare == '0, "invalid x pulse not zero")

endmodule

FILE: rtl/jsc_div.sv
// Unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps

module jsc_div import jsc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIV_W-1:0]       dividend,
    input  logic [SAMPLE_BITS-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    localparam int BITS_PER_CYCLE = 2;
    localparam int CYCLES = DIV_W / BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(CYCLES);

    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [SAMPLE_BITS-1:0] rem_step;
    logic [DIV_W-1:0]       quo_step;
    logic [SAMPLE_BITS:0]   trial;

    // Shift in one dividend bit, subtract if it fits; twice per cycle
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_step, quo_step[DIV_W-1]};
            quo_step = {quo_step[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_step    = SAMPLE_BITS'(trial - {1'b0, dvs_reg});
                quo_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[SAMPLE_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(CYCLES - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/jsc_datapath.sv
// Calibrator datapath: state, configuration, pulse mapping and output register
`timescale 1ns / 1ps

module jsc_datapath import jsc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jsc_in_t                  tick,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  jsc_cmd_t                 cmd,
    output jsc_stat_t                stat,
    output logic                     report_valid,
    input  logic                     report_ready,
    output jsc_out_t                 report
);

    localparam int PA_W = DIV_W - 1;
    localparam int PB_W = DIV_W;

    // Configuration
    logic [DEB_BITS-1:0]   deb_reg, deb_next;
    logic [PULSE_BITS-1:0] base_reg, base_next;
    logic [PULSE_BITS-1:0] span_reg, span_next;

    // Latched tick
    logic [SAMPLE_BITS-1:0] x_in_reg, x_in_next;
    logic [SAMPLE_BITS-1:0] y_in_reg, y_in_next;
    logic                   btn_in_reg, btn_in_next;

    // Calibration state
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic                   btn_cur_reg, btn_cur_next;
    logic [DEB_BITS-1:0]    steady_reg, steady_next;
    logic [SAMPLE_BITS-1:0] bxh_reg, bxh_next;
    logic [SAMPLE_BITS-1:0] bxl_reg, bxl_next;
    logic [SAMPLE_BITS-1:0] byh_reg, byh_next;
    logic [SAMPLE_BITS-1:0] byl_reg, byl_next;
    logic [PULSE_BITS-1:0]  pulse_x_reg, pulse_x_next;
    logic [PULSE_BITS-1:0]  pulse_y_reg, pulse_y_next;
    logic                   valid_x_reg, valid_x_next;
    logic                   valid_y_reg, valid_y_next;

    // Mapping pipeline
    logic [PA_W-1:0]         prod_a_reg, prod_a_next;
    logic signed [PB_W-1:0]  prod_b_reg, prod_b_next;
    logic [SAMPLE_BITS-1:0]  den_reg, den_next;
    logic                    den_zero_reg, den_zero_next;
    logic                    neg_reg, neg_next;

    // Output register
    jsc_out_t report_reg, report_next;
    logic     report_valid_reg, report_valid_next;

    logic [SAMPLE_BITS-1:0]        sel_sample, sel_hi, sel_lo;
    logic signed [SAMPLE_BITS:0]   num_raw, den_raw, num_adj, den_adj;
    logic signed [TOTAL_W-1:0]     total;
    logic                          bypass;
    logic [DIV_W-1:0]              q_full;
    logic [PULSE_BITS-1:0]         q_sat;
    logic [PULSE_BITS:0]           gap_x, gap_y;
    logic [RECIP_W-1:0]            prod_cx, prod_cy;
    logic                          out_free;
    logic                          div_busy, div_done;
    logic [DIV_W-1:0]              div_quo;

    // Operand selection and sign fold for the current axis
    always_comb
    begin
        sel_sample = cmd.axis_y ? y_in_reg : x_in_reg;
        sel_hi     = cmd.axis_y ? byh_reg : bxh_reg;
        sel_lo     = cmd.axis_y ? byl_reg : bxl_reg;
        num_raw    = $signed({1'b0, sel_sample}) - $signed({1'b0, sel_lo});
        den_raw    = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
        num_adj    = den_raw[SAMPLE_BITS] ? -num_raw : num_raw;
        den_adj    = den_raw[SAMPLE_BITS] ? -den_raw : den_raw;
        prod_a_next = PA_W'(base_reg) * PA_W'(den_adj[SAMPLE_BITS-1:0]);
        prod_b_next = PB_W'(num_adj) * $signed(PB_W'({1'b0, span_reg}));
        den_next      = den_adj[SAMPLE_BITS-1:0];
        den_zero_next = (den_raw == '0);
    end

    always_comb
    begin
        total  = $signed(TOTAL_W'(prod_a_reg)) + TOTAL_W'(prod_b_reg);
        bypass = den_zero_reg | total[TOTAL_W-1];
        neg_next = total[TOTAL_W-1];
    end

    jsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start & ~bypass),
        .dividend (total[DIV_W-1:0]),
        .divisor  (den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Pick the pulse for this axis and saturate to the period
    always_comb
    begin
        if (den_zero_reg)
            q_full = DIV_W'(base_reg);
        else if (neg_reg)
            q_full = '0;
        else
            q_full = div_quo;
        q_sat = (q_full > DIV_W'(PERIOD_US)) ? PERIOD_US : q_full[PULSE_BITS-1:0];
    end

    // Compare values: (period - pulse) / 5 by reciprocal multiply
    always_comb
    begin
        gap_x   = (PULSE_BITS+1)'(PERIOD_US) - (PULSE_BITS+1)'(pulse_x_reg);
        gap_y   = (PULSE_BITS+1)'(PERIOD_US) - (PULSE_BITS+1)'(pulse_y_reg);
        prod_cx = RECIP_W'(gap_x) * RECIP5;
        prod_cy = RECIP_W'(gap_y) * RECIP5;
    end

    assign out_free = !report_valid_reg || report_ready;

    always_comb
    begin
        deb_next     = deb_reg;
        base_next    = base_reg;
        span_next    = span_reg;
        x_in_next    = x_in_reg;
        y_in_next    = y_in_reg;
        btn_in_next  = btn_in_reg;
        phase_next   = phase_reg;
        btn_cur_next = btn_cur_reg;
        steady_next  = steady_reg;
        bxh_next     = bxh_reg;
        bxl_next     = bxl_reg;
        byh_next     = byh_reg;
        byl_next     = byl_reg;
        pulse_x_next = pulse_x_reg;
        pulse_y_next = pulse_y_reg;
        valid_x_next = valid_x_reg;
        valid_y_next = valid_y_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_LIMIT: deb_next  = cfg_data[DEB_BITS-1:0];
                CFG_PULSE_BASE:     base_next = cfg_data[PULSE_BITS-1:0];
                CFG_PULSE_SPAN:     span_next = cfg_data[PULSE_BITS-1:0];
                default: ;
            endcase
        end

        if (cmd.load_in)
        begin
            x_in_next   = tick.x_sample;
            y_in_next   = tick.y_sample;
            btn_in_next = tick.button_level;
        end

        if (cmd.store)
        begin
            if (cmd.axis_y)
            begin
                pulse_y_next = q_sat;
                valid_y_next = 1'b1;
            end
            else
            begin
                pulse_x_next = q_sat;
                valid_x_next = 1'b1;
            end
        end

        // Capture bounds and run the debounce; the done phase freezes all
        if (cmd.finish && phase_reg != PH_DONE)
        begin
            case (phase_reg)
                PH_X_MAX: bxh_next = x_in_reg;
                PH_X_MIN: bxl_next = x_in_reg;
                PH_Y_MAX: byh_next = y_in_reg;
                PH_Y_MIN: byl_next = y_in_reg;
                default: ;
            endcase
            if (btn_in_reg != btn_cur_reg)
            begin
                steady_next = '0;
                if (steady_reg > deb_reg && btn_in_reg)
                begin
                    phase_next   = phase_reg + PHASE_BITS'(1);
                    btn_cur_next = 1'b0;
                end
                else
                begin
                    btn_cur_next = btn_in_reg;
                end
            end
            else if (steady_reg != STEADY_MAX)
            begin
                steady_next = steady_reg + DEB_BITS'(1);
            end
        end
    end

    always_comb
    begin
        report_next       = report_reg;
        report_valid_next = report_valid_reg;
        if (cmd.out_load)
        begin
            report_next.phase_now     = phase_reg;
            report_next.bound_x_high  = bxh_reg;
            report_next.bound_x_low   = bxl_reg;
            report_next.bound_y_high  = byh_reg;
            report_next.bound_y_low   = byl_reg;
            report_next.x_pulse_us    = valid_x_reg ? pulse_x_reg : '0;
            report_next.y_pulse_us    = valid_y_reg ? pulse_y_reg : '0;
            report_next.x_compare     = valid_x_reg ? prod_cx[RECIP5_SHIFT +: CMP_BITS] : '0;
            report_next.y_compare     = valid_y_reg ? prod_cy[RECIP5_SHIFT +: CMP_BITS] : '0;
            report_next.x_pulse_valid = valid_x_reg;
            report_next.y_pulse_valid = valid_y_reg;
            report_valid_next         = 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg          <= DEBOUNCE_RST;
            base_reg         <= BASE_RST;
            span_reg         <= SPAN_RST;
            phase_reg        <= PH_X_MAX;
            btn_cur_reg      <= 1'b0;
            steady_reg       <= '0;
            bxh_reg          <= BOUND_RST;
            bxl_reg          <= BOUND_RST;
            byh_reg          <= BOUND_RST;
            byl_reg          <= BOUND_RST;
            pulse_x_reg      <= '0;
            pulse_y_reg      <= '0;
            valid_x_reg      <= 1'b0;
            valid_y_reg      <= 1'b0;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            deb_reg          <= deb_next;
            base_reg         <= base_next;
            span_reg         <= span_next;
            phase_reg        <= phase_next;
            btn_cur_reg      <= btn_cur_next;
            steady_reg       <= steady_next;
            bxh_reg          <= bxh_next;
            bxl_reg          <= bxl_next;
            byh_reg          <= byh_next;
            byl_reg          <= byl_next;
            pulse_x_reg      <= pulse_x_next;
            pulse_y_reg      <= pulse_y_next;
            valid_x_reg      <= valid_x_next;
            valid_y_reg      <= valid_y_next;
            report_valid_reg <= report_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_in_reg   <= x_in_next;
        y_in_reg   <= y_in_next;
        btn_in_reg <= btn_in_next;
        report_reg <= report_next;
        if (cmd.mul)
        begin
            prod_a_reg   <= prod_a_next;
            prod_b_reg   <= prod_b_next;
            den_reg      <= den_next;
            den_zero_reg <= den_zero_next;
        end
        if (cmd.div_start)
            neg_reg <= neg_next;
    end

    always_comb
    begin
        stat.map_xy   = (phase_reg == PH_MAP_XY);
        stat.map_y    = (phase_reg == PH_MAP_Y);
        stat.bypass   = bypass;
        stat.div_busy = div_busy;
        stat.div_done = div_done;
        stat.out_free = out_free;
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

FILE: rtl/jsc_ctrl.sv
// Calibrator controller: sequences one tick through the datapath
`timescale 1ns / 1ps

module jsc_ctrl import jsc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick_valid,
    output logic      tick_ready,
    input  jsc_stat_t stat,
    output jsc_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.map_xy)
                begin
                    axis_next  = 1'b0;
                    state_next = ST_MUL;
                end
                else if (stat.map_y)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:    state_next = ST_PREP;
            ST_PREP:   state_next = stat.bypass ? ST_STORE : ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (axis_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_ready    = 1'b0;
        cmd           = '0;
        cmd.axis_y    = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready  = 1'b1;
                cmd.load_in = tick_valid;
            end
            ST_MUL:    cmd.mul       = 1'b1;
            ST_PREP:   cmd.div_start = 1'b1;
            ST_STORE:  cmd.store     = 1'b1;
            ST_FINISH: cmd.finish    = 1'b1;
            ST_EMIT:   cmd.out_load  = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

FILE: test/jsc_report_checker.sv
// Calibration predictor and report scoreboard for the joystick servo calibrator
`timescale 1ns / 1ps

module jsc_report_checker import jsc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    input  logic                     tick_ready,
    input  jsc_in_t                  tick,
    input  logic                     report_valid,
    input  logic                     report_ready,
    input  jsc_out_t                 report,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       ticks_taken,
    output int                       reports_checked,
    output logic [PHASE_BITS-1:0]    phase_reached
);

    // Register copies
    logic [DEB_BITS-1:0]    limit_r;
    logic [PULSE_BITS-1:0]  base_r;
    logic [PULSE_BITS-1:0]  span_r;

    // Calibration state, bounds in phase order: x max, x min, y max, y min
    logic [PHASE_BITS-1:0]  cal_phase;
    logic                   btn_prev;
    logic                   btn_cur;
    logic [DEB_BITS-1:0]    steady;
    logic [SAMPLE_BITS-1:0] bounds [4];
    logic [PULSE_BITS-1:0]  held_x;
    logic [PULSE_BITS-1:0]  held_y;
    logic                   have_x;
    logic                   have_y;

    jsc_out_t expected_reports [$];
    jsc_out_t want;

    assign phase_reached = cal_phase;

    // base + (sample - lo) * span / (hi - lo), signed, truncated, clamped to zero and the period
    function automatic logic [PULSE_BITS-1:0] servo_width(input logic [SAMPLE_BITS-1:0] s,
                                                          input logic [SAMPLE_BITS-1:0] hi,
                                                          input logic [SAMPLE_BITS-1:0] lo);
        longint num;
        longint den;
        longint total;
        longint q;
        num = longint'(s) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (den == 0)
        begin
            q = longint'(base_r);
        end
        else
        begin
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            total = longint'(base_r) * den + num * longint'(span_r);
            if (total < 0)
                return '0;
            q = total / den;
        end
        if (q > longint'(PERIOD_US))
            q = longint'(PERIOD_US);
        return q[PULSE_BITS-1:0];
    endfunction

    function automatic logic [CMP_BITS-1:0] compare_of(input logic [PULSE_BITS-1:0] p);
        int d;
        d = (int'(PERIOD_US) - int'(p)) / 5;
        return d[CMP_BITS-1:0];
    endfunction

    // Advance the calibration by one tick and form the report it causes
    function automatic jsc_out_t calibrate_tick(input jsc_in_t t);
        jsc_out_t r;
        if (cal_phase < PH_DONE)
        begin
            if (cal_phase < PH_Y_MAX)
                bounds[cal_phase[1:0]] = t.x_sample;
            else if (cal_phase < PH_MAP_XY)
                bounds[cal_phase[1:0]] = t.y_sample;
            else
            begin
                if (cal_phase == PH_MAP_XY)
                begin
                    held_x = servo_width(t.x_sample, bounds[0], bounds[1]);
                    have_x = 1'b1;
                end
                held_y = servo_width(t.y_sample, bounds[2], bounds[3]);
                have_y = 1'b1;
            end

            btn_prev = btn_cur;
            btn_cur  = t.button_level;
            if (btn_cur != btn_prev)
            begin
                // a debounced press starts the next phase with a fresh debounce
                if (steady > limit_r && btn_cur)
                begin
                    cal_phase = cal_phase + 1'b1;
                    btn_prev  = 1'b0;
                    btn_cur   = 1'b0;
                end
                steady = '0;
            end
            else if (steady != STEADY_MAX)
            begin
                steady = steady + 1'b1;
            end
        end

        r.phase_now     = cal_phase;
        r.bound_x_high  = bounds[0];
        r.bound_x_low   = bounds[1];
        r.bound_y_high  = bounds[2];
        r.bound_y_low   = bounds[3];
        r.x_pulse_us    = have_x ? held_x : '0;
        r.y_pulse_us    = have_y ? held_y : '0;
        r.x_compare     = have_x ? compare_of(held_x) : '0;
        r.y_compare     = have_y ? compare_of(held_y) : '0;
        r.x_pulse_valid = have_x;
        r.y_pulse_valid = have_y;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_r   = DEBOUNCE_RST;
            base_r    = BASE_RST;
            span_r    = SPAN_RST;
            cal_phase = PH_X_MAX;
            btn_prev  = 1'b0;
            btn_cur   = 1'b0;
            steady    = '0;
            for (int i = 0; i < 4; i++)
                bounds[i[1:0]] = BOUND_RST;
            held_x    = '0;
            held_y    = '0;
            have_x    = 1'b0;
            have_y    = 1'b0;
            expected_reports.delete();
            pending         = 0;
            fail_count      = 0;
            ticks_taken     = 0;
            reports_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_LIMIT: limit_r = cfg_data[DEB_BITS-1:0];
                    CFG_PULSE_BASE:     base_r  = cfg_data[PULSE_BITS-1:0];
                    CFG_PULSE_SPAN:     span_r  = cfg_data[PULSE_BITS-1:0];
                    default: ;
                endcase
            end

            if (tick_valid && tick_ready)
            begin
                expected_reports.push_back(calibrate_tick(tick));
                ticks_taken++;
            end

            if (report_valid && report_ready)
            begin
                reports_checked++;
                if (expected_reports.size() == 0)
                begin
                    $error("report word arrived with no tick waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("phase_now", 16'(want.phase_now), 16'(report.phase_now));
                    check_field("bound_x_high", 16'(want.bound_x_high),
                                16'(report.bound_x_high));
                    check_field("bound_x_low", 16'(want.bound_x_low),
                                16'(report.bound_x_low));
                    check_field("bound_y_high", 16'(want.bound_y_high),
                                16'(report.bound_y_high));
                    check_field("bound_y_low", 16'(want.bound_y_low),
                                16'(report.bound_y_low));
                    check_field("x_pulse_us", 16'(want.x_pulse_us), 16'(report.x_pulse_us));
                    check_field("y_pulse_us", 16'(want.y_pulse_us), 16'(report.y_pulse_us));
                    check_field("x_compare", 16'(want.x_compare), 16'(report.x_compare));
                    check_field("y_compare", 16'(want.y_compare), 16'(report.y_compare));
                    check_field("x_pulse_valid", 16'(want.x_pulse_valid),
                                16'(report.x_pulse_valid));
                    check_field("y_pulse_valid", 16'(want.y_pulse_valid),
                                16'(report.y_pulse_valid));
                end
            end
            pending = expected_reports.size();
        end
    end

endmodule

FILE: test/tb.sv
// Stimulus, watchdog and verdict for the joystick servo calibrator
`timescale 1ns / 1ps

module tb;
    import jsc_pkg::*;

    // Longest run of cycles with no word moving on either channel. The slow case
    // is a two-axis map followed by a long receiver stall; this is many times that.
    localparam int STALL_LIMIT = 5000;
    // Drain margin at the end: a bit over the two-axis mapping latency
    localparam int TAIL_CYCLES = 60;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     tick_valid = 1'b0;
    logic                     tick_ready;
    jsc_in_t                  tick = '0;
    logic                     report_valid;
    logic                     report_ready = 1'b0;
    jsc_out_t                 report;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_DEBOUNCE_LIMIT;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int ticks_taken;
    int reports_checked;
    logic [PHASE_BITS-1:0] phase_reached;

    // Idle odds in percent for the tick sender and the report receiver
    int tx_idle = 27;
    int rx_idle = 84;
    int idle_cycles;

    logic [SAMPLE_BITS-1:0] x_hi, x_lo, y_hi, y_lo;
    int y_shape;
    int lim;

    always #6 clk = ~clk;

    joystick_servo_calibrator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    jsc_report_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_ready      (tick_ready),
        .tick            (tick),
        .report_valid    (report_valid),
        .report_ready    (report_ready),
        .report          (report),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .ticks_taken     (ticks_taken),
        .reports_checked (reports_checked),
        .phase_reached   (phase_reached)
    );

    // Receiver: re-roll ready at every falling edge so stalls land on every phase
    // of the block's work, including while a tick is queued behind a held report.
    always @(negedge clk)
    begin
        report_ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // Watchdog: count cycles in which no word moves on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((tick_valid && tick_ready) || (report_valid && report_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d reports outstanding",
                         idle_cycles, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one tick word; hold valid and payload until it is taken, then return
    // at the following falling edge with valid still high. The next offer either
    // replaces the payload or an idle gap drops valid.
    task automatic send_tick(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                             input logic b);
        jsc_in_t w;
        w.x_sample     = x;
        w.y_sample     = y;
        w.button_level = b;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            tick_valid = 1'b0;
            @(negedge clk);
        end
        tick       = w;
        tick_valid = 1'b1;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every report expected so far has come back
    task automatic settle();
        tick_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write all three registers, one per cycle; call only while settled
    task automatic set_regs(input int limit_v, input int base_v, input int span_v);
        cfg_we    = 1'b1;
        cfg_index = CFG_DEBOUNCE_LIMIT;
        cfg_data  = limit_v[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_index = CFG_PULSE_BASE;
        cfg_data  = base_v[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_index = CFG_PULSE_SPAN;
        cfg_data  = span_v[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Released button for limit+2 ticks makes the steady count exceed the limit
    // whatever it held before; the press tick then advances. That press tick is
    // also the last capture of the phase being left.
    task automatic advance_phase(input int limit_v, input logic [SAMPLE_BITS-1:0] x,
                                 input logic [SAMPLE_BITS-1:0] y);
        repeat (limit_v + 2)
            send_tick(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0);
        send_tick(x, y, 1'b1);
    endtask

    task automatic random_ticks(input int n);
        repeat (n)
            send_tick(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        // Hold reset low, then release it at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Bounce under the reset debounce limit: presses on a young count must
        // not advance. Carry sample extremes while at it.
        send_tick(12'd4095, 12'd4095, 1'b1);
        send_tick(12'd0, 12'd0, 1'b0);
        send_tick(12'd4095, 12'd0, 1'b1);
        settle();

        // Zero debounce limit: walk the four capture phases quickly
        set_regs(0, int'(BASE_RST), int'(SPAN_RST));
        x_hi = 12'($urandom_range(2500, 3800));
        x_lo = 12'($urandom_range(200, 1500));
        y_shape = $urandom_range(0, 2);
        case (y_shape)
            0:
            begin
                y_hi = 12'($urandom_range(2500, 3800));
                y_lo = 12'($urandom_range(200, 1500));
            end
            1:
            begin
                // equal bounds: y always maps to the base
                y_hi = 12'($urandom_range(0, 4095));
                y_lo = y_hi;
            end
            default:
            begin
                // inverted bounds: maximum captured below minimum
                y_lo = 12'($urandom_range(2500, 3800));
                y_hi = 12'($urandom_range(200, 1500));
            end
        endcase
        advance_phase(0, x_hi, 12'($urandom_range(0, 4095)));
        advance_phase(0, x_lo, 12'($urandom_range(0, 4095)));
        advance_phase(0, 12'($urandom_range(0, 4095)), y_hi);
        advance_phase(0, 12'($urandom_range(0, 4095)), y_lo);
        settle();

        // Now mapping both axes. Limit 255 can never be exceeded by a count that
        // saturates at 255, so random buttons keep the phase here.
        set_regs(255, int'(BASE_RST), int'(SPAN_RST));
        send_tick(12'd0, 12'd0, 1'b0);
        send_tick(12'd4095, 12'd4095, 1'b1);
        send_tick(x_lo, y_lo, 1'b0);
        send_tick(x_hi, y_hi, 1'b1);
        random_ticks(120);
        settle();

        // Swap idle odds; zero base and full span push samples outside the
        // bounds into both clamps
        tx_idle = 84;
        rx_idle = 27;
        set_regs(255, 0, 20000);
        random_ticks(100);
        settle();

        // No idling from here on
        tx_idle = 0;
        rx_idle = 0;
        set_regs(255, 20000, 20000);
        random_ticks(30);
        settle();
        set_regs(255, $urandom_range(0, 20000), $urandom_range(0, 20000));
        random_ticks(50);
        settle();

        // Step to the y-only phase with a small random limit
        lim = $urandom_range(0, 12);
        set_regs(lim, $urandom_range(0, 20000), $urandom_range(0, 20000));
        advance_phase(lim, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        settle();
        set_regs(255, $urandom_range(0, 20000), $urandom_range(0, 20000));
        random_ticks(60);
        settle();

        // Step to done; everything freezes there
        lim = $urandom_range(0, 20);
        set_regs(lim, $urandom_range(0, 20000), $urandom_range(0, 20000));
        advance_phase(lim, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        random_ticks(25);
        settle();

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("calibration walked to phase %0d: %0d ticks sent, %0d reports checked",
                 phase_reached, ticks_taken, reports_checked);
        $display("y bounds were %s; base and span swept from 0 to 20000",
                 (y_shape == 0) ? "ordered" : (y_shape == 1) ? "equal" : "inverted");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
